FILE: hw/rtl/lpad_pkg.sv
// Shared types and constants for the length-prefixed argument deframer.
// No dependencies; used by lpad_parser, lpad_result_fifo and the core top level.
package lpad_pkg;

    // Default build parameters
    localparam int MAX_ARGS_DEF  = 64;
    localparam int LEN_WIDTH_DEF = 16;

    // Result queue depth (beats)
    localparam int FIFO_DEPTH = 4;

    // Register reset value
    localparam logic [15:0] MAX_ARG_LENGTH_RST = 16'hFFFF;

    // Character codes
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_LF   = 8'h0A;

    // Input command codes
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // Parser phase, one-hot
    typedef enum logic [3:0] {
        PH_HEAD    = 4'b0001,
        PH_DIGITS  = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_DROP    = 4'b1000
    } phase_t;

    // Result kind
    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_ARG_END = 2'd1,
        KIND_STATUS  = 2'd2
    } kind_t;

    // Packet status codes
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NOT_DIGIT  = 3'd1,
        ST_NO_NEWLINE = 3'd2,
        ST_TRUNCATED  = 3'd3,
        ST_NO_FIRST   = 3'd4,
        ST_TOO_LONG   = 3'd5,
        ST_TOO_MANY   = 3'd6
    } status_t;

    // One output beat
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_out;
        logic [5:0]  arg_index;
        status_t     status;
        logic [6:0]  arg_count;
        logic        last;
    } result_t;

    // Up to two beats produced by one input beat
    typedef struct packed {
        logic [1:0]  num;
        result_t     r0;
        result_t     r1;
    } push_t;

endpackage

FILE: hw/rtl/lpad_parser.sv
// Per-byte parser state and step logic of the deframer.
// Depends on lpad_pkg; feeds lpad_result_fifo with up to two beats per input.
module lpad_parser #(
    parameter int MAX_ARGS  = lpad_pkg::MAX_ARGS_DEF,
    parameter int LEN_WIDTH = lpad_pkg::LEN_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                command,
    input  logic [7:0]          data_in,
    input  logic [15:0]         max_len,
    output lpad_pkg::push_t     push
);

    localparam int ARGW = $clog2(MAX_ARGS + 1);
    localparam int NW   = LEN_WIDTH + 4;
    localparam int CW   = (NW > 16) ? NW : 16;

    lpad_pkg::phase_t    phase_reg, phase_next;
    logic [LEN_WIDTH-1:0] len_reg, len_next;
    logic [ARGW-1:0]     args_reg, args_next;
    logic                first_empty_reg, first_empty_next;
    lpad_pkg::status_t   err_reg, err_next;

    logic                is_digit;
    logic [7:0]          digit_off;
    logic [LEN_WIDTH-1:0] len_base;
    logic [NW-1:0]       base_ext;
    logic [NW-1:0]       len_acc;
    logic                too_long;
    logic [ARGW+6:0]     args_ext;
    lpad_pkg::status_t   end_status;

    // Digit decode and length accumulate: len * 10 + digit
    assign is_digit  = (data_in >= lpad_pkg::CHAR_ZERO) && (data_in <= lpad_pkg::CHAR_NINE);
    assign digit_off = data_in - lpad_pkg::CHAR_ZERO;
    assign len_base  = (phase_reg == lpad_pkg::PH_HEAD) ? '0 : len_reg;
    assign base_ext  = NW'(len_base);
    assign len_acc   = (base_ext << 3) + (base_ext << 1) + NW'(digit_off[3:0]);
    assign too_long  = (len_acc[NW-1:LEN_WIDTH] != '0) || (CW'(len_acc) > CW'(max_len));

    // Argument count widened so the output fields can be cut from it
    assign args_ext = {7'b0, args_reg};

    // Status reported by an end command
    always_comb
    begin
        end_status = err_reg;
        if (err_reg == lpad_pkg::ST_OK)
        begin
            if (phase_reg == lpad_pkg::PH_DIGITS)
                end_status = lpad_pkg::ST_NO_NEWLINE;
            else if (phase_reg == lpad_pkg::PH_PAYLOAD)
                end_status = lpad_pkg::ST_TRUNCATED;
            else if ((args_reg == '0) || first_empty_reg)
                end_status = lpad_pkg::ST_NO_FIRST;
        end
    end

    // Step logic for one accepted beat
    always_comb
    begin
        phase_next       = phase_reg;
        len_next         = len_reg;
        args_next        = args_reg;
        first_empty_next = first_empty_reg;
        err_next         = err_reg;
        push             = '0;

        if (in_valid)
        begin
            if (command == lpad_pkg::CMD_END)
            begin
                push.num          = 2'd1;
                push.r0.kind      = lpad_pkg::KIND_STATUS;
                push.r0.status    = end_status;
                push.r0.arg_count = args_ext[6:0];
                push.r0.last      = 1'b1;
                phase_next        = lpad_pkg::PH_HEAD;
                len_next          = '0;
                args_next         = '0;
                first_empty_next  = 1'b0;
                err_next          = lpad_pkg::ST_OK;
            end
            else
            begin
                case (phase_reg)
                    lpad_pkg::PH_HEAD:
                    begin
                        if (!is_digit)
                        begin
                            err_next   = lpad_pkg::ST_NOT_DIGIT;
                            phase_next = lpad_pkg::PH_DROP;
                        end
                        else if (args_reg >= ARGW'(MAX_ARGS))
                        begin
                            err_next   = lpad_pkg::ST_TOO_MANY;
                            phase_next = lpad_pkg::PH_DROP;
                        end
                        else if (too_long)
                        begin
                            err_next   = lpad_pkg::ST_TOO_LONG;
                            phase_next = lpad_pkg::PH_DROP;
                        end
                        else
                        begin
                            len_next   = len_acc[LEN_WIDTH-1:0];
                            phase_next = lpad_pkg::PH_DIGITS;
                        end
                    end
                    lpad_pkg::PH_DIGITS:
                    begin
                        if (is_digit)
                        begin
                            if (too_long)
                            begin
                                err_next   = lpad_pkg::ST_TOO_LONG;
                                phase_next = lpad_pkg::PH_DROP;
                            end
                            else
                                len_next = len_acc[LEN_WIDTH-1:0];
                        end
                        else if (data_in != lpad_pkg::CHAR_LF)
                        begin
                            err_next   = lpad_pkg::ST_NO_NEWLINE;
                            phase_next = lpad_pkg::PH_DROP;
                        end
                        else if (len_reg == '0)
                        begin
                            // empty argument: end marker right away
                            if (args_reg == '0)
                                first_empty_next = 1'b1;
                            push.num          = 2'd1;
                            push.r0.kind      = lpad_pkg::KIND_ARG_END;
                            push.r0.arg_index = args_ext[5:0];
                            push.r0.last      = 1'b1;
                            args_next         = args_reg + 1'b1;
                            phase_next        = lpad_pkg::PH_HEAD;
                        end
                        else
                            phase_next = lpad_pkg::PH_PAYLOAD;
                    end
                    lpad_pkg::PH_PAYLOAD:
                    begin
                        len_next          = len_reg - 1'b1;
                        push.r0.kind      = lpad_pkg::KIND_PAYLOAD;
                        push.r0.data_out  = data_in;
                        push.r0.arg_index = args_ext[5:0];
                        if (len_reg == LEN_WIDTH'(1))
                        begin
                            // final payload byte, then end marker
                            push.num          = 2'd2;
                            push.r0.last      = 1'b0;
                            push.r1.kind      = lpad_pkg::KIND_ARG_END;
                            push.r1.arg_index = args_ext[5:0];
                            push.r1.last      = 1'b1;
                            args_next         = args_reg + 1'b1;
                            phase_next        = lpad_pkg::PH_HEAD;
                        end
                        else
                        begin
                            push.num     = 2'd1;
                            push.r0.last = 1'b1;
                        end
                    end
                    default:
                    begin
                        // dropping after an error
                    end
                endcase
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= lpad_pkg::PH_HEAD;
            len_reg         <= '0;
            args_reg        <= '0;
            first_empty_reg <= 1'b0;
            err_reg         <= lpad_pkg::ST_OK;
        end
        else
        begin
            phase_reg       <= phase_next;
            len_reg         <= len_next;
            args_reg        <= args_next;
            first_empty_reg <= first_empty_next;
            err_reg         <= err_next;
        end
    end

`ifndef ASSERT_OFF
    // payload phase always has bytes left to take
    a_payload_len: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == lpad_pkg::PH_PAYLOAD) |-> (len_reg != '0))
        else $error("payload phase with zero remaining length");

    // argument count never passes the limit
    a_args_bound: assert property (@(posedge clk) disable iff (!rst_n)
        args_reg <= ARGW'(MAX_ARGS))
        else $error("argument count above limit");

    // an error code is only held while dropping
    a_err_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != lpad_pkg::ST_OK) |-> (phase_reg == lpad_pkg::PH_DROP))
        else $error("error latched outside drop phase");
`endif

endmodule

FILE: hw/rtl/lpad_result_fifo.sv
// Small result queue: takes up to two beats per cycle, emits one per cycle while out_ready is high.
// Depends on lpad_pkg; sits between lpad_parser and the master stream port.
module lpad_result_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  lpad_pkg::push_t     push,
    output logic                space,
    output logic                out_valid,
    input  logic                out_ready,
    output lpad_pkg::result_t   out_beat
);

    localparam int DEPTH = lpad_pkg::FIFO_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CNTW  = $clog2(DEPTH + 1);

    lpad_pkg::result_t mem_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]   count_reg, count_next;
    logic [PW-1:0]     wr_ptr_inc;
    logic              pop;

    // Room for a two-beat push, independent of the downstream ready
    assign space     = (count_reg <= CNTW'(DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_beat  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign wr_ptr_inc = wr_ptr_reg + 1'b1;

    // Pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(push.num);
        rd_ptr_next = pop ? (rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg + CNTW'(push.num) - CNTW'(pop);
    end

    // Storage writes
    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0)
            mem_reg[wr_ptr_reg] <= push.r0;
        if (push.num == 2'd2)
            mem_reg[wr_ptr_inc] <= push.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef ASSERT_OFF
    // pushes only arrive when a two-beat push fits
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push.num != 2'd0) |-> space)
        else $error("result queue push without room");

    // a pop with no push shrinks the fill by one
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && (push.num == 2'd0)) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("result queue fill count mismatch");
`endif

endmodule

FILE: hw/rtl/length_prefixed_argument_deframer_core.sv
// Top level of the length-prefixed argument deframer: stream ports and limit register.
// Depends on lpad_pkg, lpad_parser and lpad_result_fifo.

// Takes one packet byte or end command per cycle on the slave stream. Each
// byte is parsed combinationally and its results (none, one, or two beats)
// land in a four-beat result queue that drives the master stream, so the
// first result appears in the cycle after the input beat. s_tready drops only
// while the queue holds more than two beats, which happens only when the
// downstream stalls: two-beat items (final payload byte plus argument-end
// marker) are at least three input beats apart, so with m_tready held high
// the queue never passes two beats and the sustained rate is one input beat
// per cycle. m_tuser carries the result kind; on an error status the
// consumer discards the packet's payload beats.
module length_prefixed_argument_deframer_core #(
    parameter int MAX_ARGS  = lpad_pkg::MAX_ARGS_DEF,
    parameter int LEN_WIDTH = lpad_pkg::LEN_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // limit register
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,   // max_arg_length
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] data_in
    input  logic        s_tuser,     // [0] command
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,     // [7:0] data_out, [13:8] arg_index,
                                     // [16:14] status, [23:17] arg_count
    output logic [1:0]  m_tuser,     // [1:0] kind
    output logic        m_tlast      // last
);

    logic [15:0]        max_len_reg;
    logic               in_valid;
    lpad_pkg::push_t    push;
    lpad_pkg::result_t  out_beat;

    // Limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= lpad_pkg::MAX_ARG_LENGTH_RST;
        else if (cfg_we)
            max_len_reg <= cfg_wdata;
    end

    assign in_valid = s_tvalid && s_tready;

    lpad_parser #(
        .MAX_ARGS  (MAX_ARGS),
        .LEN_WIDTH (LEN_WIDTH)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (s_tuser),
        .data_in  (s_tdata),
        .max_len  (max_len_reg),
        .push     (push)
    );

    lpad_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space     (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_beat  (out_beat)
    );

    // Result beat packing
    assign m_tdata = {out_beat.arg_count, out_beat.status, out_beat.arg_index,
                      out_beat.data_out};
    assign m_tuser = out_beat.kind;
    assign m_tlast = out_beat.last;

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for length_prefixed_argument_deframer_core.
// Needs lpad_pkg and the core RTL. It sends directed and random packets, predicts
// every result beat and compares each one as it leaves the block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lpad_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_BEATS = 450;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = 16'h0000;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tuser = CMD_BYTE;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    length_prefixed_argument_deframer_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Shadow copy of the parser state
    phase_t      shadow_phase = PH_HEAD;
    int unsigned shadow_len = 0;
    int unsigned args_seen = 0;
    bit          first_empty = 1'b0;
    status_t     pkt_err = ST_OK;
    int unsigned max_len = 65535;

    result_t expected_beats[$];
    int      mismatches = 0;
    int      beats_sent = 0;
    int      cycles = 0;
    bit      quiet = 1'b0;

    // One row of the directed plan; status and count apply to typed rows only
    typedef struct {
        logic       cmd;
        logic [7:0] dat;
        bit         typed;
        status_t    st;
        logic [6:0] cnt;
    } plan_row_t;

    plan_row_t plan [30] = '{
        // end with nothing framed
        '{CMD_END,  8'h00,              1'b1, ST_NO_FIRST,   7'd0},
        // empty first argument
        '{CMD_BYTE, CHAR_ZERO,          1'b0, ST_OK,         7'd0},
        '{CMD_BYTE, CHAR_LF,            1'b0, ST_OK,         7'd0},
        '{CMD_END,  8'h00,              1'b1, ST_NO_FIRST,   7'd1},
        // two arguments: payload extremes, then an empty one
        '{CMD_BYTE, CHAR_ZERO + 8'd2,   1'b0, ST_OK,         7'd0},
        '{CMD_BYTE, CHAR_LF,            1'b0, ST_OK,         7'd0},
        '{CMD_BYTE, 8'h00,              1'b0, ST_OK,         7'd0},
        '{CMD_BYTE, 8'hFF,              1'b0, ST_OK,         7'd0},
        '{CMD_BYTE, CHAR_ZERO,          1'b0, ST_OK,         7'd0},
        '{CMD_BYTE, CHAR_LF,            1'b0, ST_OK,         7'd0},
        '{CMD_END,  8'hFF,              1'b1, ST_OK,         7'd2},
        // header just above '9', then a dropped digit
        '{CMD_BYTE, CHAR_NINE + 8'd1,   1'b0, ST_OK,         7'd0},
        '{CMD_BYTE, CHAR_ZERO + 8'd5,   1'b0, ST_OK,         7'd0},
        '{CMD_END,  8'h00,              1'b1, ST_NOT_DIGIT,  7'd0},
        // byte just below '0' where the newline belongs
        '{CMD_BYTE, CHAR_ZERO + 8'd3,   1'b0, ST_OK,         7'd0},
        '{CMD_BYTE, CHAR_ZERO - 8'd1,   1'b0, ST_OK,         7'd0},
        '{CMD_END,  8'h00,              1'b1, ST_NO_NEWLINE, 7'd0},
        // end inside the digits
        '{CMD_BYTE, CHAR_ZERO + 8'd1,   1'b0, ST_OK,         7'd0},
        '{CMD_BYTE, CHAR_ZERO + 8'd2,   1'b0, ST_OK,         7'd0},
        '{CMD_END,  8'h00,              1'b1, ST_NO_NEWLINE, 7'd0},
        // end inside the payload
        '{CMD_BYTE, CHAR_ZERO + 8'd3,   1'b0, ST_OK,         7'd0},
        '{CMD_BYTE, CHAR_LF,            1'b0, ST_OK,         7'd0},
        '{CMD_BYTE, 8'h61,              1'b0, ST_OK,         7'd0},
        '{CMD_END,  8'h00,              1'b1, ST_TRUNCATED,  7'd0},
        // declared length one past the counter range
        '{CMD_BYTE, CHAR_ZERO + 8'd6,   1'b0, ST_OK,         7'd0},
        '{CMD_BYTE, CHAR_ZERO + 8'd5,   1'b0, ST_OK,         7'd0},
        '{CMD_BYTE, CHAR_ZERO + 8'd5,   1'b0, ST_OK,         7'd0},
        '{CMD_BYTE, CHAR_ZERO + 8'd3,   1'b0, ST_OK,         7'd0},
        '{CMD_BYTE, CHAR_ZERO + 8'd6,   1'b0, ST_OK,         7'd0},
        '{CMD_END,  8'h00,              1'b1, ST_TOO_LONG,   7'd0}
    };

    // Clock and cycle limit
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("** length_prefixed_argument_deframer_core: FAILED **");
            $finish;
        end
    end

    function automatic result_t make_beat(kind_t k, logic [7:0] d, logic [5:0] idx,
                                          status_t st, logic [6:0] cnt, logic lst);
        result_t r;
        r.kind      = k;
        r.data_out  = d;
        r.arg_index = idx;
        r.status    = st;
        r.arg_count = cnt;
        r.last      = lst;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
    endtask

    // Parse one accepted beat on the shadow state; n results in r0, r1
    task automatic deframe_byte(input logic cmd, input logic [7:0] b,
                                output result_t r0, output result_t r1, output int n);
        bit          is_digit;
        int unsigned dval;
        status_t     st;
        is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
        dval = b - CHAR_ZERO;
        n = 0;
        r0 = '0;
        r1 = '0;
        if (cmd == CMD_END)
        begin
            st = pkt_err;
            if (st == ST_OK)
            begin
                if (shadow_phase == PH_DIGITS)
                    st = ST_NO_NEWLINE;
                else if (shadow_phase == PH_PAYLOAD)
                    st = ST_TRUNCATED;
                else if (args_seen == 0 || first_empty)
                    st = ST_NO_FIRST;
            end
            r0 = make_beat(KIND_STATUS, 8'h00, 6'd0, st, args_seen[6:0], 1'b1);
            n = 1;
            shadow_phase = PH_HEAD;
            shadow_len = 0;
            args_seen = 0;
            first_empty = 1'b0;
            pkt_err = ST_OK;
        end
        else
        begin
            case (shadow_phase)
                PH_HEAD:
                begin
                    if (!is_digit)
                    begin
                        pkt_err = ST_NOT_DIGIT;
                        shadow_phase = PH_DROP;
                    end
                    else if (args_seen >= MAX_ARGS_DEF)
                    begin
                        pkt_err = ST_TOO_MANY;
                        shadow_phase = PH_DROP;
                    end
                    else
                    begin
                        shadow_len = dval;
                        if (shadow_len > max_len)
                        begin
                            pkt_err = ST_TOO_LONG;
                            shadow_phase = PH_DROP;
                        end
                        else
                            shadow_phase = PH_DIGITS;
                    end
                end
                PH_DIGITS:
                begin
                    if (is_digit)
                    begin
                        shadow_len = shadow_len * 10 + dval;
                        if (shadow_len > max_len)
                        begin
                            pkt_err = ST_TOO_LONG;
                            shadow_phase = PH_DROP;
                        end
                    end
                    else if (b != CHAR_LF)
                    begin
                        pkt_err = ST_NO_NEWLINE;
                        shadow_phase = PH_DROP;
                    end
                    else if (shadow_len == 0)
                    begin
                        if (args_seen == 0)
                            first_empty = 1'b1;
                        r0 = make_beat(KIND_ARG_END, 8'h00, args_seen[5:0], ST_OK, 7'd0, 1'b1);
                        n = 1;
                        args_seen++;
                        shadow_phase = PH_HEAD;
                    end
                    else
                        shadow_phase = PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    shadow_len--;
                    if (shadow_len == 0)
                    begin
                        r0 = make_beat(KIND_PAYLOAD, b, args_seen[5:0], ST_OK, 7'd0, 1'b0);
                        r1 = make_beat(KIND_ARG_END, 8'h00, args_seen[5:0], ST_OK, 7'd0, 1'b1);
                        n = 2;
                        args_seen++;
                        shadow_phase = PH_HEAD;
                    end
                    else
                    begin
                        r0 = make_beat(KIND_PAYLOAD, b, args_seen[5:0], ST_OK, 7'd0, 1'b1);
                        n = 1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    endtask

    // Drive one input beat, wait for it to be taken, record what it should produce
    task automatic send_beat(input logic cmd, input logic [7:0] b,
                             input bit typed, input result_t typed_res);
        result_t r0, r1;
        int      n;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        deframe_byte(cmd, b, r0, r1, n);
        if (typed)
            expected_beats.push_back(typed_res);
        else
        begin
            if (n > 0)
                expected_beats.push_back(r0);
            if (n > 1)
                expected_beats.push_back(r1);
        end
        beats_sent++;
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
    endtask

    // Limit register is written only with the block idle
    task automatic write_limit(input logic [15:0] v);
        hold_until_drained();
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we  <= 1'b0;
        max_len = v;
    endtask

    task automatic send_packet(ref logic [7:0] pkt[$]);
        foreach (pkt[i])
        begin
            if (!quiet && $urandom_range(0, 59) == 0)
                hold_until_drained();
            send_beat(CMD_BYTE, pkt[i], 1'b0, '0);
        end
        send_beat(CMD_END, 8'($urandom_range(0, 255)), 1'b0, '0);
    endtask

    // Mostly well-formed packet with random content, sometimes broken
    task automatic random_packet();
        logic [7:0] pkt[$];
        int         nargs;
        int         len;
        int         sel;
        int         pos;
        bit         cut_short;
        string      digits;
        nargs = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 5);
        cut_short = 1'b0;
        for (int a = 0; a < nargs && !cut_short; a++)
        begin
            sel = $urandom_range(0, 19);
            if (sel < 11)
                len = $urandom_range(0, 4);
            else if (sel < 15)
                len = $urandom_range(5, 24);
            else if (sel == 15)
                len = (max_len <= 24) ? int'(max_len) : $urandom_range(0, 4);
            else if (sel == 16)
                len = int'(max_len) + 1;
            else if (sel == 17)
                len = $urandom_range(0, 65535);
            else
                len = $urandom_range(65536, 99999);
            digits = $sformatf("%0d", len);
            if ($urandom_range(0, 7) == 0)
                digits = {"0", digits};
            for (int i = 0; i < digits.len(); i++)
                pkt.push_back(digits[i]);
            pkt.push_back(CHAR_LF);
            // long declared lengths are never filled: a few bytes, then the end
            if (len > 24)
            begin
                repeat ($urandom_range(0, 3)) pkt.push_back(8'($urandom_range(0, 255)));
                cut_short = 1'b1;
            end
            else
                repeat (len) pkt.push_back(8'($urandom_range(0, 255)));
        end
        // damage one packet in five
        if (pkt.size() != 0 && $urandom_range(0, 4) == 0)
        begin
            pos = $urandom_range(0, pkt.size() - 1);
            case ($urandom_range(0, 2))
                0: pkt[pos] = 8'($urandom_range(0, 255));
                1: while (pkt.size() > pos) void'(pkt.pop_back());
                default: pkt.insert(pos, 8'($urandom_range(0, 255)));
            endcase
        end
        send_packet(pkt);
    endtask

    // Full argument table, optionally with one header too many
    task automatic many_args(input bit overflow);
        logic [7:0] pkt[$];
        int         len;
        for (int a = 0; a < MAX_ARGS_DEF; a++)
        begin
            len = (a == 0) ? $urandom_range(1, 2) : $urandom_range(0, 1);
            pkt.push_back(CHAR_ZERO + 8'(len));
            pkt.push_back(CHAR_LF);
            repeat (len) pkt.push_back(8'($urandom_range(0, 255)));
        end
        if (overflow)
            pkt.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
        send_packet(pkt);
    endtask

    // Result side: random stalls, none in the closing part
    initial
    begin
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            if (!quiet)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid === 1'b1 && m_tready)
        begin
            if (expected_beats.size() == 0)
                flag_mismatch("unexpected beat", {6'd0, m_tuser, m_tdata}, 32'd0);
            else
            begin
                want = expected_beats.pop_front();
                if (m_tuser !== want.kind)
                    flag_mismatch("kind", 32'(m_tuser), 32'(want.kind));
                if (m_tdata[7:0] !== want.data_out)
                    flag_mismatch("data_out", 32'(m_tdata[7:0]), 32'(want.data_out));
                if (m_tdata[13:8] !== want.arg_index)
                    flag_mismatch("arg_index", 32'(m_tdata[13:8]), 32'(want.arg_index));
                if (m_tdata[16:14] !== want.status)
                    flag_mismatch("status", 32'(m_tdata[16:14]), 32'(want.status));
                if (m_tdata[23:17] !== want.arg_count)
                    flag_mismatch("arg_count", 32'(m_tdata[23:17]), 32'(want.arg_count));
                if (m_tlast !== want.last)
                    flag_mismatch("last", 32'(m_tlast), 32'(want.last));
            end
        end
    end

    // Stimulus
    initial
    begin
        logic [15:0] lim;
        int          pass_no;
        int          phase_base;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed plan at the reset limit
        foreach (plan[i])
            send_beat(plan[i].cmd, plan[i].dat, plan[i].typed,
                      make_beat(KIND_STATUS, 8'h00, 6'd0, plan[i].st, plan[i].cnt, 1'b1));

        // random packets over a cycle of limit settings
        pass_no = 0;
        while (beats_sent < $size(plan) + RANDOM_BEATS)
        begin
            case (pass_no % 7)
                0: lim = 16'h0000;
                1: lim = 16'h0001;
                2: lim = 16'hFFFF;
                3: lim = 16'h0003;
                4: lim = 16'($urandom_range(0, 65535));
                5: lim = 16'($urandom_range(2, 30));
                default: lim = 16'hFFFF;
            endcase
            write_limit(lim);
            if (pass_no == 2)
            begin
                many_args(1'b0);
                many_args(1'b1);
            end
            phase_base = beats_sent;
            while (beats_sent - phase_base < 40)
            begin
                if (beats_sent >= $size(plan) + RANDOM_BEATS - 50)
                    quiet = 1'b1;
                random_packet();
            end
            pass_no++;
        end

        // drain and check nothing trails
        quiet = 1'b1;
        hold_until_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("** length_prefixed_argument_deframer_core: PASSED **");
        else
            $display("** length_prefixed_argument_deframer_core: FAILED **");
        $finish;
    end

endmodule
